FILE: hw/rtl/swts_pkg.sv
// ----------------------------------------------------------------------------
// swts_pkg
// shared types and constants of the sorted word table search block
// ----------------------------------------------------------------------------
package swts_pkg;

  localparam int unsigned MaxChars   = 8;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned SelW       = (MaxChars > 1) ? $clog2(MaxChars) : 1;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned AddrW      = SelW + IdxW;
  localparam int unsigned MemDepth   = MaxChars * TableDepth;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActSort   = 2'd2,
    ActSearch = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StMiss = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  word_length;
    logic [63:0] packed_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [10:0] table_count;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic cnt_clear;   // zero selected count
    logic cnt_inc;     // bump selected count
    logic mem_wr_word; // write request word at count
    logic srch_init;   // first = 0, last = n (one above the real bound)
    logic srch_rd;     // read at mid
    logic srch_step;   // narrow range using read data
    logic sort_init;   // i = 1
    logic sort_rd_i;   // read t[i]
    logic sort_cap_v;  // v = rdata, j = i
    logic sort_rd_j;   // read t[j-1]
    logic sort_shift;  // t[j] = rdata, j--
    logic sort_place;  // t[j] = v, i++
    logic rsp_load;    // build result
  } cmd_t;

  typedef struct packed {
    logic len_bad;
    logic full;
    logic srch_done;   // range empty
    logic srch_hit;    // read data equals word
    logic sort_done;   // i >= n
    logic j_zero;
    logic gt;          // read data > v
  } sts_t;

endpackage

FILE: hw/rtl/swts_if.sv
// ----------------------------------------------------------------------------
// swts_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface swts_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/swts_ctrl.sv
// ----------------------------------------------------------------------------
// swts_ctrl
// sequencer for clear, append, sort and search
// ----------------------------------------------------------------------------
module swts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     action_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  swts_pkg::sts_t sts_i,
  output swts_pkg::cmd_t cmd_o
);
  import swts_pkg::*;

  typedef enum logic [9:0] {
    SIdle   = 10'b0000000001,
    SDecode = 10'b0000000010,
    SSrRd   = 10'b0000000100,
    SSrCmp  = 10'b0000001000,
    SStRdI  = 10'b0000010000,
    SStCapV = 10'b0000100000,
    SStRdJ  = 10'b0001000000,
    SStCmp  = 10'b0010000000,
    SDone   = 10'b0100000000,
    SOut    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] act_q, act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          act_d      = action_i;
          state_d    = SDecode;
        end
      end
      SDecode: begin
        if (sts_i.len_bad) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = SOut;
        end else begin
          unique case (act_q)
            ActClear: begin
              cmd_o.cnt_clear = 1'b1;
              cmd_o.rsp_load  = 1'b1;
              state_d         = SOut;
            end
            ActAppend: begin
              cmd_o.rsp_load = 1'b1;
              if (!sts_i.full) begin
                cmd_o.mem_wr_word = 1'b1;
                cmd_o.cnt_inc     = 1'b1;
              end
              state_d = SOut;
            end
            ActSort: begin
              cmd_o.sort_init = 1'b1;
              state_d         = SStRdI;
            end
            default: begin
              cmd_o.srch_init = 1'b1;
              state_d         = SSrRd;
            end
          endcase
        end
      end
      SSrRd: begin
        if (sts_i.srch_done) begin
          state_d = SDone;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = SSrCmp;
        end
      end
      SSrCmp: begin
        if (sts_i.srch_hit) begin
          state_d = SDone;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d         = SSrRd;
        end
      end
      SStRdI: begin
        if (sts_i.sort_done) begin
          state_d = SDone;
        end else begin
          cmd_o.sort_rd_i = 1'b1;
          state_d         = SStCapV;
        end
      end
      SStCapV: begin
        cmd_o.sort_cap_v = 1'b1;
        state_d          = SStRdJ;
      end
      SStRdJ: begin
        if (sts_i.j_zero) begin
          cmd_o.sort_place = 1'b1;
          state_d          = SStRdI;
        end else begin
          cmd_o.sort_rd_j = 1'b1;
          state_d         = SStCmp;
        end
      end
      SStCmp: begin
        if (sts_i.gt) begin
          cmd_o.sort_shift = 1'b1;
          state_d          = SStRdJ;
        end else begin
          cmd_o.sort_place = 1'b1;
          state_d          = SStRdI;
        end
      end
      SDone: begin
        cmd_o.rsp_load = 1'b1;
        state_d        = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && !out_ready_i) |=> state_q == SOut)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == SDecode)
    else $error("load did not decode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mem_wr_word, cmd_o.sort_shift, cmd_o.sort_place}))
    else $error("two memory writes");
endmodule

FILE: hw/rtl/swts_dp.sv
// ----------------------------------------------------------------------------
// swts_dp
// word memory, count registers, search and insertion-sort registers
// ----------------------------------------------------------------------------
module swts_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  swts_pkg::req_t req_i,
  input  swts_pkg::cmd_t cmd_i,
  output swts_pkg::sts_t sts_o,
  output swts_pkg::rsp_t rsp_o
);
  import swts_pkg::*;

  logic [63:0] mem [MemDepth];
  logic [63:0] rdata_q;

  logic [1:0]      act_q;
  logic [63:0]     word_q;
  logic            bad_q;
  logic [SelW-1:0] sel_q;
  logic [CntW-1:0] cnt_q [MaxChars];
  logic [CntW-1:0] n;

  logic [CntW:0]   first_q, last_q; // last held one above the real bound
  logic [CntW-1:0] mid_q, i_q, j_q;
  logic [63:0]     v_q;
  rsp_t            rsp_q;

  logic [3:0]  len;
  logic [63:0] masked;
  logic [CntW:0] midsum;
  logic [CntW-1:0] mid;

  logic            mem_we;
  logic            mem_re;
  logic [IdxW-1:0] mem_idx;
  logic [63:0]     mem_wdata;

  assign len = req_i.word_length;
  always_comb begin
    masked = req_i.packed_word;
    for (int k = 1; k < 8; k++) begin
      if (len == 4'(k)) masked = req_i.packed_word & ((64'd1 << (8 * k)) - 64'd1);
    end
  end

  assign n = cnt_q[sel_q];

  // last_q uses an offset of one so it never goes negative
  assign midsum = first_q + last_q - (CntW+1)'(1);
  assign mid    = midsum[CntW:1];

  // single memory port, the commands never overlap
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_idx   = '0;
    mem_wdata = word_q;
    if (cmd_i.mem_wr_word) begin
      mem_we  = 1'b1;
      mem_idx = n[IdxW-1:0];
    end else if (cmd_i.sort_shift) begin
      mem_we    = 1'b1;
      mem_idx   = j_q[IdxW-1:0];
      mem_wdata = rdata_q;
    end else if (cmd_i.sort_place) begin
      mem_we    = 1'b1;
      mem_idx   = j_q[IdxW-1:0];
      mem_wdata = v_q;
    end else if (cmd_i.srch_rd) begin
      mem_re  = 1'b1;
      mem_idx = mid[IdxW-1:0];
    end else if (cmd_i.sort_rd_i) begin
      mem_re  = 1'b1;
      mem_idx = i_q[IdxW-1:0];
    end else if (cmd_i.sort_rd_j) begin
      mem_re  = 1'b1;
      mem_idx = IdxW'(j_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{sel_q, mem_idx}] <= mem_wdata;
    if (mem_re) rdata_q <= mem[{sel_q, mem_idx}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxChars; k++) cnt_q[k] <= '0;
      act_q  <= ActClear;
      word_q <= '0;
      bad_q  <= 1'b0;
      sel_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q  <= req_i.action;
        word_q <= masked;
        bad_q  <= (len == 4'd0) || (len > 4'(MaxChars));
        sel_q  <= SelW'(len - 4'd1);
      end
      if (!bad_q) begin
        if (cmd_i.cnt_clear) cnt_q[sel_q] <= '0;
        else if (cmd_i.cnt_inc) cnt_q[sel_q] <= n + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_rd) mid_q <= mid;
    if (cmd_i.srch_init) begin
      first_q <= '0;
      last_q  <= {1'b0, n};
    end
    if (cmd_i.srch_step) begin
      if (rdata_q > word_q) last_q <= {1'b0, mid_q};
      else first_q <= {1'b0, mid_q} + (CntW+1)'(1);
    end
    if (cmd_i.sort_init) i_q <= CntW'(1);
    if (cmd_i.sort_cap_v) begin
      v_q <= rdata_q;
      j_q <= i_q;
    end
    if (cmd_i.sort_shift) j_q <= j_q - CntW'(1);
    if (cmd_i.sort_place) i_q <= i_q + CntW'(1);
    if (cmd_i.rsp_load) begin
      rsp_q.entry_index <= '0;
      rsp_q.status      <= StOk;
      rsp_q.table_count <= 11'(n);
      if (bad_q) begin
        rsp_q.status      <= StMiss;
        rsp_q.table_count <= '0;
      end else begin
        unique case (act_q)
          ActClear: rsp_q.table_count <= '0;
          ActAppend: begin
            if (n >= CntW'(TableDepth)) rsp_q.status <= StFull;
            else begin
              rsp_q.entry_index <= 10'(n);
              rsp_q.table_count <= 11'(n + CntW'(1));
            end
          end
          ActSort: ;
          default: begin
            if (rdata_q == word_q && first_q < last_q) rsp_q.entry_index <= 10'(mid_q);
            else rsp_q.status <= StMiss;
          end
        endcase
      end
    end
  end

  assign sts_o.len_bad   = bad_q;
  assign sts_o.full      = (n >= CntW'(TableDepth));
  assign sts_o.srch_done = (first_q >= last_q);
  assign sts_o.srch_hit  = (rdata_q == word_q);
  assign sts_o.sort_done = (i_q >= n);
  assign sts_o.j_zero    = (j_q == '0);
  assign sts_o.gt        = (rdata_q > v_q);
  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bad_q |-> n <= CntW'(TableDepth))
    else $error("count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sort_shift |-> j_q != '0)
    else $error("shift past start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_rd |-> first_q < last_q)
    else $error("read outside range");
endmodule

FILE: hw/rtl/sorted_word_table_search.sv
// ----------------------------------------------------------------------------
// sorted_word_table_search
// per-length word tables with append, insertion sort and binary search
// ----------------------------------------------------------------------------
// clear/append/bad length: SDecode builds the result, valid in SOut until taken
// search: binary search with one registered memory read per probe (SSrRd, SSrCmp),
//   at most 11 probes at depth 1024
// sort: insertion sort through SStRdI, SStCapV, SStRdJ and SStCmp, O(n^2)
// one word in flight; next word accepted the cycle after the result is taken
// reset clears all table counts at once; word memory holds no reset
module sorted_word_table_search (
  input logic clk_i,
  input logic rst_ni,
  swts_if.sink   req_if,
  swts_if.source rsp_if
);
  import swts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  req_t req;

  assign req = req_if.data;

  swts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .action_i    (req.action),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swts_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign rsp_if.data = rsp;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives words into sorted_word_table_search through the request channel,
// predicts every result from a local copy of the tables and checks each
// result field by field, in order, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
  import swts_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SortCap    = 48;   // keep sorts cheap

  class table_scoreboard;
    logic [63:0] words [MaxChars][TableDepth];
    int unsigned counts [MaxChars];
    rsp_t        expected_q [$];
    int unsigned errors;

    function new();
      foreach (counts[i]) counts[i] = 0;
      errors = 0;
    endfunction

    function int unsigned count_of(int unsigned len);
      if (len < 1 || len > MaxChars) return 0;
      return counts[len-1];
    endfunction

    // stored word with random junk above the used bytes
    function logic [63:0] stored_word(int unsigned len);
      logic [63:0] w;
      logic [63:0] junk;
      w = words[len-1][$urandom_range(counts[len-1]-1, 0)];
      junk = {$urandom, $urandom};
      if (len < 8) w = w | (junk << (8 * len));
      return w;
    endfunction

    function void note_request(req_t rq);
      rsp_t        r;
      int unsigned sel;
      int unsigned n;
      int          first;
      int          last;
      int          mid;
      int          j;
      logic [63:0] w;
      logic [63:0] v;
      r = '0;
      w = rq.packed_word;
      if (rq.word_length < 1 || rq.word_length > MaxChars) begin
        r.status = StMiss;
        expected_q.push_back(r);
        return;
      end
      if (rq.word_length < 8) w = w & ((64'd1 << (8 * rq.word_length)) - 64'd1);
      sel = rq.word_length - 1;
      n = counts[sel];
      case (action_e'(rq.action))
        ActClear: begin
          counts[sel] = 0;
          r.status = StOk;
        end
        ActAppend: begin
          if (n >= TableDepth) begin
            r.status = StFull;
            r.table_count = 11'(n);
          end else begin
            words[sel][n] = w;
            counts[sel] = n + 1;
            r.status = StOk;
            r.entry_index = 10'(n);
            r.table_count = 11'(n + 1);
          end
        end
        ActSort: begin
          for (int i = 1; i < int'(n); i++) begin
            v = words[sel][i];
            j = i;
            while (j > 0 && words[sel][j-1] > v) begin
              words[sel][j] = words[sel][j-1];
              j--;
            end
            words[sel][j] = v;
          end
          r.status = StOk;
          r.table_count = 11'(n);
        end
        default: begin
          r.status = StMiss;
          r.table_count = 11'(n);
          first = 0;
          last = int'(n) - 1;
          while (first <= last) begin
            mid = (first + last) / 2;
            if (words[sel][mid] == w) begin
              r.status = StOk;
              r.entry_index = 10'(mid);
              break;
            end
            if (words[sel][mid] > w) last = mid - 1;
            else first = mid + 1;
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(got), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.entry_index !== want.entry_index)
        report("entry_index", 64'(got.entry_index), 64'(want.entry_index));
      if (got.table_count !== want.table_count)
        report("table_count", 64'(got.table_count), 64'(want.table_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  swts_if #(.T(req_t)) req_if ();
  swts_if #(.T(rsp_t)) rsp_if ();

  sorted_word_table_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if.sink),
    .rsp_if (rsp_if.source)
  );

  table_scoreboard tables = new();
  int unsigned     send_idle_pct = 8;
  int unsigned     recv_stall_pct = 71;
  bit              hold_rsp = 1'b0;
  int unsigned     cycles = 0;

  always #6 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni || hold_rsp) rsp_if.ready = 1'b0;
    else rsp_if.ready = ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) tables.check_result(rsp_if.data);
  end

  task send_word(action_e act, int unsigned len, logic [63:0] w);
    req_t rq;
    rq.action = act;
    rq.word_length = len[3:0];
    rq.packed_word = w;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data = rq;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    tables.note_request(rq);
  endtask

  function logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task random_word(bit allow_bad_len);
    int unsigned len;
    int unsigned n;
    int unsigned pick;
    if (allow_bad_len && $urandom_range(99, 0) < 6) begin
      len = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(15, 9);
      send_word(action_e'($urandom_range(3, 0)), len, rand_word());
      return;
    end
    len = $urandom_range(MaxChars, 1);
    n = tables.count_of(len);
    pick = $urandom_range(99, 0);
    if (pick < 10 || (pick < 50 && n >= 40)) send_word(ActClear, len, rand_word());
    else if (pick < 50) send_word(ActAppend, len, rand_word());
    else if (pick < 60) begin
      if (n <= SortCap) send_word(ActSort, len, rand_word());
      else send_word(ActClear, len, rand_word());
    end else if (n > 0 && $urandom_range(99, 0) < 70)
      send_word(ActSearch, len, tables.stored_word(len));
    else send_word(ActSearch, len, rand_word());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty tables, bad lengths, extremes, duplicates, unsorted search
    send_word(ActSearch, 1, 64'h0);
    send_word(ActSort, 1, 64'h0);
    for (int a = 0; a < 4; a++) begin
      send_word(action_e'(a), 0, '1);
      send_word(action_e'(a), 15, '1);
    end
    send_word(ActAppend, 8, '1);
    send_word(ActAppend, 8, 64'h0);
    send_word(ActAppend, 8, 64'h0);
    send_word(ActAppend, 8, 64'h8000_0000_0000_0001);
    send_word(ActSearch, 8, 64'h0);
    send_word(ActSort, 8, 64'h0);
    send_word(ActSearch, 8, '1);
    send_word(ActSearch, 8, 64'h0);
    send_word(ActSearch, 8, 64'h1234);
    send_word(ActAppend, 1, '1);
    send_word(ActAppend, 1, 64'hFFFF_FFFF_FFFF_FF00);
    send_word(ActSearch, 1, 64'h0000_0000_0000_00FF);
    send_word(ActClear, 8, 64'h0);
    send_word(ActSearch, 8, 64'h0);

    // fill one table to capacity, then overflow it
    send_word(ActClear, 7, 64'h0);
    for (int i = 0; i < TableDepth + 2; i++) send_word(ActAppend, 7, rand_word());
    for (int i = 0; i < 20; i++)
      send_word(ActSearch, 7, (i % 2) ? tables.stored_word(7) : rand_word());
    send_word(ActClear, 7, 64'h0);

    // other way round, with a long hold-off on the result side
    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (tables.expected_q.size() == 0);
    send_idle_pct = 71;
    recv_stall_pct = 8;
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 150; i++) random_word(1'b1);
    join

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 150; i++) random_word(1'b1);

    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (tables.expected_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (tables.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
